FILE: sv/cee_pkg.sv
package cee_pkg;
    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_LOAD  = 4'b0010,
        B_PAIR  = 4'b0100,
        B_OUT   = 4'b1000
    } back_state_t;
endpackage

FILE: sv/cee_if.sv
interface cee_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/cee_front.sv
module cee_front #(
    parameter int MAX_LAYER_HITS = 64,
    parameter int COORD_BITS     = 24,
    parameter int LAYER_BITS     = 12
) (
    input  logic clk,
    input  logic rst_n,
    cee_if.sink  hit,
    input  logic back_busy,
    output logic done_valid,
    output logic done_status,
    output logic [$clog2(MAX_LAYER_HITS+1)-1:0] done_fcount,
    output logic [$clog2(MAX_LAYER_HITS+1)-1:0] done_ccount,
    output logic done_use_cur,
    output logic [3*COORD_BITS-1:0] done_least,
    output logic [3*COORD_BITS-1:0] done_greatest,
    input  logic [$clog2(MAX_LAYER_HITS)-1:0] rd_addr,
    input  logic rd_sel,
    output logic [3*COORD_BITS-1:0] rd_data
);
    localparam int CW = $clog2(MAX_LAYER_HITS+1);
    localparam int AW = $clog2(MAX_LAYER_HITS);
    localparam int PW = 3*COORD_BITS;

    logic [PW-1:0] first_mem [MAX_LAYER_HITS];
    logic [PW-1:0] cur_mem   [MAX_LAYER_HITS];
    logic [CW-1:0] fcount_reg, ccount_reg;
    logic [LAYER_BITS-1:0] flayer_reg, clayer_reg;
    logic started_reg, ovf_reg;
    logic [PW-1:0] least_reg, great_reg;

    logic [COORD_BITS-1:0] px, py, pz;
    logic [LAYER_BITS-1:0] lay;
    logic last, acc;
    logic [LAYER_BITS-1:0] flayer_eff;
    logic [CW-1:0] fc_eff, cc_eff;
    logic to_first, f_full, c_full;
    logic [PW-1:0] least_next, great_next, pnt;

    assign {last, lay, pz, py, px} = hit.data;
    assign pnt = {pz, py, px};
    assign hit.ready = !back_busy;
    assign acc = hit.valid && hit.ready;

    always_comb
    begin
        flayer_eff = started_reg ? flayer_reg : lay;
        fc_eff = started_reg ? fcount_reg : '0;
        cc_eff = (started_reg && lay == clayer_reg) ? ccount_reg : '0;
        to_first = (lay == flayer_eff);
        f_full = (fc_eff == CW'(MAX_LAYER_HITS));
        c_full = (cc_eff == CW'(MAX_LAYER_HITS));
        least_next = least_reg;
        great_next = great_reg;
        if (!started_reg)
        begin
            least_next = pnt;
            great_next = pnt;
        end
        else
        begin
            if ($signed(px) < $signed(least_reg[COORD_BITS-1:0]))
                least_next = pnt;
            if ($signed(px) > $signed(great_reg[COORD_BITS-1:0]))
                great_next = pnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && to_first && !f_full)
            first_mem[fc_eff[AW-1:0]] <= pnt;
        if (acc && !c_full)
            cur_mem[cc_eff[AW-1:0]] <= pnt;
        rd_data <= rd_sel ? cur_mem[rd_addr] : first_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcount_reg  <= '0;
            ccount_reg  <= '0;
            flayer_reg  <= '0;
            clayer_reg  <= '0;
            started_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            least_reg   <= '0;
            great_reg   <= '0;
            done_valid  <= 1'b0;
        end
        else
        begin
            done_valid <= 1'b0;
            if (acc)
            begin
                if (last)
                begin
                    done_valid    <= 1'b1;
                    done_status   <= ovf_reg || (to_first && f_full) || c_full;
                    done_fcount   <= (to_first && !f_full) ? fc_eff + 1'b1 : fc_eff;
                    done_ccount   <= !c_full ? cc_eff + 1'b1 : cc_eff;
                    done_use_cur  <= (lay != flayer_eff);
                    done_least    <= least_next;
                    done_greatest <= great_next;
                    started_reg <= 1'b0;
                    ovf_reg     <= 1'b0;
                    fcount_reg  <= '0;
                    ccount_reg  <= '0;
                    flayer_reg  <= '0;
                    clayer_reg  <= '0;
                    least_reg   <= '0;
                    great_reg   <= '0;
                end
                else
                begin
                    started_reg <= 1'b1;
                    flayer_reg  <= flayer_eff;
                    clayer_reg  <= lay;
                    least_reg   <= least_next;
                    great_reg   <= great_next;
                    if (to_first && !f_full)
                        fcount_reg <= fc_eff + 1'b1;
                    else
                        fcount_reg <= fc_eff;
                    ccount_reg <= !c_full ? cc_eff + 1'b1 : cc_eff;
                    if ((to_first && f_full) || c_full)
                        ovf_reg <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: sv/cee_back.sv
module cee_back #(
    parameter int MAX_LAYER_HITS = 64,
    parameter int COORD_BITS     = 24
) (
    input  logic clk,
    input  logic rst_n,
    input  logic done_valid,
    input  logic done_status,
    input  logic [$clog2(MAX_LAYER_HITS+1)-1:0] done_fcount,
    input  logic [$clog2(MAX_LAYER_HITS+1)-1:0] done_ccount,
    input  logic done_use_cur,
    input  logic [3*COORD_BITS-1:0] done_least,
    input  logic [3*COORD_BITS-1:0] done_greatest,
    output logic busy,
    output logic [$clog2(MAX_LAYER_HITS)-1:0] rd_addr,
    output logic rd_sel,
    input  logic [3*COORD_BITS-1:0] rd_data,
    cee_if.source res
);
    localparam int CW = $clog2(MAX_LAYER_HITS+1);
    localparam int AW = $clog2(MAX_LAYER_HITS);
    localparam int PW = 3*COORD_BITS;
    localparam int NMAX = 2*MAX_LAYER_HITS + 2;
    localparam int NW = $clog2(NMAX+1);
    localparam int IW = $clog2(NMAX);
    localparam int DW = COORD_BITS + 1;
    localparam int SW = 2*DW + 2;

    cee_pkg::back_state_t state_reg;
    logic [PW-1:0] cand_mem [NMAX];
    logic [NW-1:0] n_reg, ld_reg;
    logic [IW-1:0] i_reg, j_reg;
    logic [PW-1:0] least_reg, great_reg, a_reg, b_reg, ci_reg, cj_reg;
    logic [PW-1:0] ea_reg, eb_reg;
    logic [SW-1:0] best_reg, d_reg;
    logic status_reg, ld_v_reg, d_v_reg, e_v_reg, rd_v_reg;
    logic [IW-1:0] ld_dst_reg;
    logic [CW-1:0] fcnt_reg;
    logic [PW-1:0] pi_reg, pj_reg;
    logic pij_v_reg;
    logic [PW-1:0] ld_pnt;

    logic signed [DW-1:0] dx, dy, dz;
    logic [SW-1:0] d_sum;
    logic [PW-1:0] inner, outer;
    logic signed [DW-1:0] oz, ox;

    assign busy = (state_reg != cee_pkg::B_IDLE);

    always_comb
    begin
        dx = DW'($signed(ci_reg[COORD_BITS-1:0])) - DW'($signed(cj_reg[COORD_BITS-1:0]));
        dy = DW'($signed(ci_reg[2*COORD_BITS-1:COORD_BITS]))
           - DW'($signed(cj_reg[2*COORD_BITS-1:COORD_BITS]));
        dz = DW'($signed(ci_reg[PW-1:2*COORD_BITS])) - DW'($signed(cj_reg[PW-1:2*COORD_BITS]));
        d_sum = SW'(dx*dx) + SW'(dy*dy) + SW'(dz*dz);
        oz = DW'($signed(b_reg[PW-1:2*COORD_BITS])) - DW'($signed(a_reg[PW-1:2*COORD_BITS]));
        ox = DW'($signed(b_reg[COORD_BITS-1:0])) - DW'($signed(a_reg[COORD_BITS-1:0]));
        if (oz > 0 || (oz == 0 && ox > 0))
        begin
            inner = a_reg;
            outer = b_reg;
        end
        else
        begin
            inner = b_reg;
            outer = a_reg;
        end
        // loader: first stores, then current store, then least/greatest
        if (ld_reg < NW'(fcnt_reg))
        begin
            rd_sel  = 1'b0;
            rd_addr = AW'(ld_reg);
        end
        else
        begin
            rd_sel  = 1'b1;
            rd_addr = AW'(ld_reg - NW'(fcnt_reg));
        end
        if (NW'(ld_dst_reg) == n_reg - NW'(2))
            ld_pnt = least_reg;
        else if (NW'(ld_dst_reg) == n_reg - 1'b1)
            ld_pnt = great_reg;
        else
            ld_pnt = rd_data;
    end

    always_ff @(posedge clk)
    begin
        if (ld_v_reg)
            cand_mem[ld_dst_reg] <= ld_pnt;
        pi_reg <= cand_mem[i_reg];
        pj_reg <= cand_mem[j_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cee_pkg::B_IDLE;
            res.valid <= 1'b0;
            ld_v_reg  <= 1'b0;
            pij_v_reg <= 1'b0;
            d_v_reg   <= 1'b0;
            e_v_reg   <= 1'b0;
            rd_v_reg  <= 1'b0;
        end
        else
        begin
            ld_v_reg <= 1'b0;
            unique case (state_reg)
                cee_pkg::B_IDLE:
                begin
                    if (done_valid)
                    begin
                        fcnt_reg   <= done_fcount;
                        least_reg  <= done_least;
                        great_reg  <= done_greatest;
                        status_reg <= done_status;
                        ld_reg     <= '0;
                        n_reg      <= NW'(done_fcount) + (done_use_cur ? NW'(done_ccount) : '0)
                                      + NW'(2);
                        state_reg  <= cee_pkg::B_LOAD;
                    end
                end
                cee_pkg::B_LOAD:
                begin
                    // the store read data is registered; ld_v_reg and ld_dst_reg delay the write to match
                    if (ld_reg < n_reg)
                    begin
                        ld_v_reg   <= 1'b1;
                        ld_dst_reg <= IW'(ld_reg);
                        ld_reg     <= ld_reg + 1'b1;
                    end
                    else
                    begin
                        a_reg     <= least_reg;
                        b_reg     <= great_reg;
                        best_reg  <= '0;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        rd_v_reg  <= 1'b1;
                        pij_v_reg <= 1'b0;
                        d_v_reg   <= 1'b0;
                        e_v_reg   <= 1'b0;
                        state_reg <= cee_pkg::B_PAIR;
                    end
                end
                cee_pkg::B_PAIR:
                begin
                    // stage 1: read pair, stage 2: operands, stage 3: distance, stage 4: compare
                    pij_v_reg <= rd_v_reg;
                    ci_reg  <= pi_reg;
                    cj_reg  <= pj_reg;
                    d_v_reg <= pij_v_reg;
                    d_reg   <= d_sum;
                    ea_reg  <= ci_reg;
                    eb_reg  <= cj_reg;
                    e_v_reg <= d_v_reg;
                    if (rd_v_reg)
                    begin
                        if (NW'(j_reg) + 1'b1 < n_reg)
                            j_reg <= j_reg + 1'b1;
                        else if (NW'(i_reg) + 1'b1 < n_reg)
                        begin
                            i_reg <= i_reg + 1'b1;
                            j_reg <= i_reg + 1'b1;
                        end
                        else
                            rd_v_reg <= 1'b0;
                    end
                    if (e_v_reg && d_reg > best_reg)
                    begin
                        best_reg <= d_reg;
                        a_reg    <= ea_reg;
                        b_reg    <= eb_reg;
                    end
                    if (e_v_reg && !d_v_reg && !pij_v_reg && !rd_v_reg)
                        state_reg <= cee_pkg::B_OUT;
                end
                cee_pkg::B_OUT:
                begin
                    if (!res.valid)
                    begin
                        res.valid <= 1'b1;
                        res.data  <= {status_reg, outer, inner};
                    end
                    else if (res.ready)
                    begin
                        res.valid <= 1'b0;
                        state_reg <= cee_pkg::B_IDLE;
                    end
                end
                default: state_reg <= cee_pkg::B_IDLE;
            endcase
        end
    end
endmodule

FILE: sv/cluster_extremal_endpoints_unit.sv
// Hits are taken one per cycle while the back end is idle and no finished cluster is being handed over.
// After the last hit the back end loads the candidates and then searches them;
// the search compares one pair of its N candidates per cycle, N = stored candidates + 2.
// The next cluster is accepted once the result beat has been taken.
// rst_n is asynchronous and active low; it clears all control state.
module cluster_extremal_endpoints_unit #(
    parameter int MAX_LAYER_HITS = 64,
    parameter int COORD_BITS     = 24,
    parameter int LAYER_BITS     = 12
) (
    input logic clk,
    input logic rst_n,
    cee_if.sink   hit,
    cee_if.source res
);
    localparam int CW = $clog2(MAX_LAYER_HITS+1);
    localparam int AW = $clog2(MAX_LAYER_HITS);
    localparam int PW = 3*COORD_BITS;

    logic busy, dv, ds, duc, rsel;
    logic [CW-1:0] dfc, dcc;
    logic [PW-1:0] dl, dg, rdata;
    logic [AW-1:0] raddr;

    cee_front #(.MAX_LAYER_HITS(MAX_LAYER_HITS), .COORD_BITS(COORD_BITS),
                .LAYER_BITS(LAYER_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .hit(hit), .back_busy(busy || dv),
        .done_valid(dv), .done_status(ds), .done_fcount(dfc), .done_ccount(dcc),
        .done_use_cur(duc), .done_least(dl), .done_greatest(dg),
        .rd_addr(raddr), .rd_sel(rsel), .rd_data(rdata));

    cee_back #(.MAX_LAYER_HITS(MAX_LAYER_HITS), .COORD_BITS(COORD_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .done_valid(dv), .done_status(ds),
        .done_fcount(dfc), .done_ccount(dcc), .done_use_cur(duc),
        .done_least(dl), .done_greatest(dg), .busy(busy),
        .rd_addr(raddr), .rd_sel(rsel), .rd_data(rdata), .res(res));
endmodule

FILE: sv/cee_checker.sv
module cee_checker (
    input logic clk,
    input logic rst_n,
    input logic hit_valid,
    input logic hit_ready,
    input logic res_valid,
    input logic res_ready
);
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");
    a_no_hit_during_res: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !hit_ready)
        else $error("hit taken while result pending");
    a_gap_after_res: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> !res_valid)
        else $error("result repeated");
    a_hit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && !hit_ready |=> hit_valid)
        else $error("hit withdrawn while stalled");
endmodule

bind cluster_extremal_endpoints_unit cee_checker u_chk (
    .clk(clk), .rst_n(rst_n), .hit_valid(hit.valid), .hit_ready(hit.ready),
    .res_valid(res.valid), .res_ready(res.ready));
